// ===== rtl/irlin_pkg.sv =====
// shared types and constants for the infrared range linearizer
// no dependencies; compiled before every other file of the block

package irlin_pkg;

   localparam int SAMPLE_BITS       = 12;
   localparam int DIST_BITS         = 10;
   localparam int INDEX_BITS        = 4;
   localparam int CHANNELS          = 3;
   localparam int TABLE_ENTRIES_DEF = 14;

   localparam int ENTRY_BITS = SAMPLE_BITS + DIST_BITS;
   localparam int PROD_BITS  = SAMPLE_BITS + DIST_BITS;
   localparam int STEP_BITS  = $clog2(DIST_BITS);
   localparam int CH_BITS    = $clog2(CHANNELS);

   // request operation codes
   localparam logic OP_CONVERT = 1'b0;
   localparam logic OP_WRITE   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } irlin_state_type;

endpackage

// ===== rtl/irlin_req_if.sv =====
// request channel of the range linearizer: convert or table write
// depends on irlin_pkg for field widths

interface irlin_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [irlin_pkg::SAMPLE_BITS-1:0] sample_a;
   logic [irlin_pkg::SAMPLE_BITS-1:0] sample_b;
   logic [irlin_pkg::SAMPLE_BITS-1:0] sample_c;
   logic [irlin_pkg::INDEX_BITS-1:0]  entry_index;
   logic [irlin_pkg::SAMPLE_BITS-1:0] entry_threshold;
   logic [irlin_pkg::DIST_BITS-1:0]   entry_distance;

   modport source (
      output valid, op, sample_a, sample_b, sample_c,
      output entry_index, entry_threshold, entry_distance,
      input  ready
   );

   modport sink (
      input  valid, op, sample_a, sample_b, sample_c,
      input  entry_index, entry_threshold, entry_distance,
      output ready
   );
endinterface

// ===== rtl/irlin_rsp_if.sv =====
// result channel of the range linearizer: three distances
// depends on irlin_pkg for field widths

interface irlin_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [irlin_pkg::DIST_BITS-1:0] distance_a;
   logic [irlin_pkg::DIST_BITS-1:0] distance_b;
   logic [irlin_pkg::DIST_BITS-1:0] distance_c;

   modport source (
      output valid, distance_a, distance_b, distance_c,
      input  ready
   );

   modport sink (
      input  valid, distance_a, distance_b, distance_c,
      output ready
   );
endinterface

// ===== rtl/ir_range_linearizer_top.sv =====
// infrared range linearizer: a table write completes on accept and ready stays high
// convert: the table is scanned through the ram read port, then each channel in turn
// passes the shared multiply and restoring divider; out-of-window requests go back
// to idle after the check with no result. one request in flight; a waiting result
// does not block accept
// reset clears control only; the calibration table is undefined until written

module ir_range_linearizer_top #(
   parameter int TABLE_ENTRIES = irlin_pkg::TABLE_ENTRIES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   irlin_req_if.sink     req_bus,
   irlin_rsp_if.source   rsp_bus
);

   localparam int SB  = irlin_pkg::SAMPLE_BITS;
   localparam int DB  = irlin_pkg::DIST_BITS;
   localparam int NCH = irlin_pkg::CHANNELS;
   localparam int PB  = irlin_pkg::PROD_BITS;
   localparam int EB  = irlin_pkg::ENTRY_BITS;
   localparam int STB = irlin_pkg::STEP_BITS;
   localparam int CHB = irlin_pkg::CH_BITS;
   localparam int AW  = $clog2(TABLE_ENTRIES);
   localparam int CW  = $clog2(TABLE_ENTRIES + 1);

   irlin_pkg::irlin_state_type state_ff, state_in;

   logic [CW-1:0]  addr_ff, addr_in;
   logic [CHB-1:0] ch_ff, ch_in;
   logic [STB-1:0] step_ff, step_in;

   logic [SB-1:0]  s_ff [NCH];
   logic [SB-1:0]  s_in [NCH];
   logic [SB-1:0]  thi_ff [NCH];
   logic [SB-1:0]  thi_in [NCH];
   logic [SB-1:0]  tlo_ff [NCH];
   logic [SB-1:0]  tlo_in [NCH];
   logic [DB-1:0]  dp_ff [NCH];
   logic [DB-1:0]  dp_in [NCH];
   logic [DB-1:0]  dc_ff [NCH];
   logic [DB-1:0]  dc_in [NCH];
   logic [NCH-1:0] found_ff, found_in;
   logic [DB-1:0]  res_ff [NCH];
   logic [DB-1:0]  res_in [NCH];

   logic [SB-1:0]  prev_thr_ff, prev_thr_in;
   logic [DB-1:0]  prev_dist_ff, prev_dist_in;
   logic [SB-1:0]  thr_first_ff, thr_first_in;
   logic [SB-1:0]  thr_last_ff, thr_last_in;

   logic [PB-1:0]  rem_ff, rem_in;
   logic [PB-1:0]  dvs_ff, dvs_in;
   logic [DB-1:0]  quo_ff, quo_in;
   logic           neg_ff, neg_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [DB-1:0]  rsp_dist_ff [NCH];
   logic [DB-1:0]  rsp_dist_in [NCH];

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [EB-1:0]  ram_wdata;
   logic [EB-1:0]  ram_rdata;
   logic [SB-1:0]  rd_thr;
   logic [DB-1:0]  rd_dist;

   assign rd_thr  = ram_rdata[EB-1:DB];
   assign rd_dist = ram_rdata[DB-1:0];

   irlin_ram #(
      .WIDTH (EB),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_bus.ready      = (state_ff == irlin_pkg::ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.distance_a = rsp_dist_ff[0];
   assign rsp_bus.distance_b = rsp_dist_ff[1];
   assign rsp_bus.distance_c = rsp_dist_ff[2];

   always_comb begin
      logic          win_ok;
      logic          take;
      logic          dneg;
      logic [DB-1:0] mag;
      logic [SB-1:0] span;
      logic [SB-1:0] den;
      logic [DB:0]   fin;

      state_in     = state_ff;
      addr_in      = addr_ff;
      ch_in        = ch_ff;
      step_in      = step_ff;
      s_in         = s_ff;
      thi_in       = thi_ff;
      tlo_in       = tlo_ff;
      dp_in        = dp_ff;
      dc_in        = dc_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      prev_thr_in  = prev_thr_ff;
      prev_dist_in = prev_dist_ff;
      thr_first_in = thr_first_ff;
      thr_last_in  = thr_last_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ram_we       = 1'b0;
      ram_waddr    = AW'(req_bus.entry_index);
      ram_wdata    = {req_bus.entry_threshold, req_bus.entry_distance};
      win_ok       = 1'b0;
      take         = 1'b0;
      dneg         = 1'b0;
      mag          = '0;
      span         = '0;
      den          = '0;
      fin          = '0;

      unique case (state_ff)
         irlin_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.op == irlin_pkg::OP_WRITE) begin
                  // writes beyond the table are dropped
                  ram_we = (32'(req_bus.entry_index) < TABLE_ENTRIES);
               end else begin
                  s_in[0]  = req_bus.sample_a;
                  s_in[1]  = req_bus.sample_b;
                  s_in[2]  = req_bus.sample_c;
                  addr_in  = '0;
                  found_in = '0;
                  state_in = irlin_pkg::ST_SCAN;
               end
            end
         end

         irlin_pkg::ST_SCAN: begin
            addr_in = CW'(addr_ff + 1'b1);
            // read data comes from the registered ram read: entry index is addr_ff - 1
            if (addr_ff != '0) begin
               if (addr_ff == CW'(1)) begin
                  thr_first_in = rd_thr;
               end
               if (addr_ff == CW'(TABLE_ENTRIES)) begin
                  thr_last_in = rd_thr;
               end
               for (int c = 0; c < NCH; c++) begin
                  take = !found_ff[c] && (addr_ff >= CW'(2)) &&
                         ((rd_thr <= s_ff[c]) || (addr_ff == CW'(TABLE_ENTRIES)));
                  if (take) begin
                     found_in[c] = 1'b1;
                     thi_in[c]   = prev_thr_ff;
                     tlo_in[c]   = rd_thr;
                     dp_in[c]    = prev_dist_ff;
                     dc_in[c]    = rd_dist;
                  end
               end
               prev_thr_in  = rd_thr;
               prev_dist_in = rd_dist;
            end
            if (addr_ff == CW'(TABLE_ENTRIES)) begin
               state_in = irlin_pkg::ST_CHECK;
            end
         end

         irlin_pkg::ST_CHECK: begin
            win_ok = (s_ff[0] != '0);
            for (int c = 0; c < NCH; c++) begin
               win_ok = win_ok && (s_ff[c] > thr_last_ff) && (s_ff[c] < thr_first_ff);
            end
            ch_in    = '0;
            state_in = win_ok ? irlin_pkg::ST_MUL : irlin_pkg::ST_IDLE;
         end

         irlin_pkg::ST_MUL: begin
            // magnitude of the slope term; sign handled after the divide
            dneg    = (dc_ff[ch_ff] < dp_ff[ch_ff]);
            mag     = dneg ? DB'(dp_ff[ch_ff] - dc_ff[ch_ff])
                           : DB'(dc_ff[ch_ff] - dp_ff[ch_ff]);
            span    = SB'(thi_ff[ch_ff] - s_ff[ch_ff]);
            den     = SB'(thi_ff[ch_ff] - tlo_ff[ch_ff]);
            rem_in  = PB'(mag) * PB'(span);
            dvs_in  = PB'(den) << (DB - 1);
            quo_in  = '0;
            neg_in  = dneg;
            step_in = '0;
            state_in = irlin_pkg::ST_DIV;
         end

         irlin_pkg::ST_DIV: begin
            // span <= den keeps the quotient below 2^DIST_BITS
            if (rem_ff >= dvs_ff) begin
               rem_in = PB'(rem_ff - dvs_ff);
               quo_in = {quo_ff[DB-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[DB-2:0], 1'b0};
            end
            dvs_in  = dvs_ff >> 1;
            step_in = STB'(step_ff + 1'b1);
            if (step_ff == STB'(DB - 1)) begin
               state_in = irlin_pkg::ST_FIN;
            end
         end

         irlin_pkg::ST_FIN: begin
            // floor division: a negative inexact quotient rounds one further down
            if (neg_ff) begin
               fin = {1'b0, dp_ff[ch_ff]} - {1'b0, quo_ff} - (DB+1)'(rem_ff != '0);
            end else begin
               fin = {1'b0, dp_ff[ch_ff]} + {1'b0, quo_ff};
            end
            res_in[ch_ff] = fin[DB-1:0];
            if (ch_ff == CHB'(NCH - 1)) begin
               state_in = irlin_pkg::ST_DONE;
            end else begin
               ch_in    = CHB'(ch_ff + 1'b1);
               state_in = irlin_pkg::ST_MUL;
            end
         end

         irlin_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_dist_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = irlin_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = irlin_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irlin_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
         ch_ff        <= '0;
         step_ff      <= '0;
         found_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      thi_ff       <= thi_in;
      tlo_ff       <= tlo_in;
      dp_ff        <= dp_in;
      dc_ff        <= dc_in;
      res_ff       <= res_in;
      prev_thr_ff  <= prev_thr_in;
      prev_dist_ff <= prev_dist_in;
      thr_first_ff <= thr_first_in;
      thr_last_ff  <= thr_last_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

endmodule

// ===== rtl/irlin_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module irlin_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
